// ----- hdl/rgb_3x3_kernel_filter_macros.svh -----
// Assertion helpers shared by the filter modules.
`ifndef RGB_3X3_KERNEL_FILTER_MACROS_SVH
`define RGB_3X3_KERNEL_FILTER_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define RGBK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define RGBK_ASSERT_NEXT(label, pre, post, msg) \
    `RGBK_ASSERT(label, pre |=> post, msg)

`endif

// ----- hdl/rgbk_pkg.sv -----
package rgbk_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int DIM_W      = 11;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int POS_W      = 10;
    localparam int QDEPTH     = 2;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        MODE_HILINE = 2'd0,
        MODE_GAUSS  = 2'd1,
        MODE_EMBOSS = 2'd2,
        MODE_AVG    = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
    } t_cfg;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pix;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       frame_start;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]       red_out;
        logic [7:0]       green_out;
        logic [7:0]       blue_out;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             last_of_frame;
    } t_out_beat;

    // px[row][col] of the 3x3 window, plus the center position
    typedef struct packed {
        t_pix [2:0][2:0]  px;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_win;

endpackage

// ----- hdl/rgbk_queue.sv -----
module rgbk_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rgbk_pkg::t_win i_data,
    output logic           o_full,
    input  logic           i_pop,
    output rgbk_pkg::t_win o_data,
    output logic           o_empty
);

    localparam int PTR_W = (rgbk_pkg::QDEPTH > 1) ? $clog2(rgbk_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(rgbk_pkg::QDEPTH + 1);

    rgbk_pkg::t_win   r_mem [rgbk_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CNT_W'(rgbk_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (wr_en) begin
            n_wr = (r_wr == PTR_W'(rgbk_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (rd_en) begin
            n_rd = (r_rd == PTR_W'(rgbk_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- hdl/rgbk_front.sv -----
`include "rgb_3x3_kernel_filter_macros.svh"

module rgbk_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rgbk_pkg::t_cfg     i_cfg,
    input  logic               i_push,
    input  rgbk_pkg::t_in_beat i_pix,
    output logic               o_full,
    output logic               o_q_push,
    output rgbk_pkg::t_win     o_q_data,
    input  logic               i_q_full
);

    localparam int DW = rgbk_pkg::DIM_W;

    logic [DW-1:0] w, h, c0, c1, r0, r1, cn, rn;
    logic [rgbk_pkg::COL_W-1:0] r_col, n_col, c_addr;
    logic [rgbk_pkg::ROW_W-1:0] r_row, n_row;
    logic accept, b_adv, emit, last, fwd;
    rgbk_pkg::t_pix cur;

    rgbk_pkg::t_pix mem_above [rgbk_pkg::MAX_WIDTH];
    rgbk_pkg::t_pix mem_two   [rgbk_pkg::MAX_WIDTH];
    rgbk_pkg::t_pix r_rd_above, r_rd_two;

    logic                       r_b_valid;
    logic                       r_b_emit, r_b_last, r_b_fwd;
    rgbk_pkg::t_pix             r_b_cur, r_b_fwd_above, r_b_fwd_two;
    logic [rgbk_pkg::COL_W-1:0] r_b_c;
    logic [rgbk_pkg::POS_W-1:0] r_b_orow, r_b_ocol;
    rgbk_pkg::t_pix             b_col0, b_col1;
    rgbk_pkg::t_pix [2:0]       r_win0, r_win1;

    assign w = (i_cfg.width < DW'(3)) ? DW'(3) :
               (i_cfg.width > DW'(rgbk_pkg::MAX_WIDTH)) ? DW'(rgbk_pkg::MAX_WIDTH) : i_cfg.width;
    assign h = (i_cfg.height < DW'(3)) ? DW'(3) :
               (i_cfg.height > DW'(rgbk_pkg::MAX_HEIGHT)) ? DW'(rgbk_pkg::MAX_HEIGHT) :
               i_cfg.height;

    assign b_adv  = r_b_valid && (!r_b_emit || !i_q_full);
    assign o_full = r_b_valid && !b_adv;
    assign accept = i_push && !o_full;

    assign cur.red   = i_pix.red_in;
    assign cur.green = i_pix.green_in;
    assign cur.blue  = i_pix.blue_in;

    // position of this pixel and of the next one
    always_comb begin
        c0 = i_pix.frame_start ? '0 : DW'(r_col);
        r0 = i_pix.frame_start ? '0 : DW'(r_row);
        c1 = c0;
        r1 = r0;
        if (c0 >= w) begin
            c1 = '0;
            r1 = r0 + 1'b1;
        end
        if (r1 >= h) begin
            r1 = '0;
        end
        cn    = c1 + 1'b1;
        rn    = r1;
        n_col = cn[rgbk_pkg::COL_W-1:0];
        if (cn >= w) begin
            n_col = '0;
            rn    = r1 + 1'b1;
            if (rn >= h) begin
                rn = '0;
            end
        end
        n_row  = rn[rgbk_pkg::ROW_W-1:0];
        c_addr = c1[rgbk_pkg::COL_W-1:0];
        emit   = (r1 >= DW'(2)) && (c1 >= DW'(2));
        last   = (r1 == h - 1'b1) && (c1 == w - 1'b1);
        fwd    = r_b_valid && (r_b_c == c_addr);
    end

    // store written by the item in stage B on the same cycle as this read
    assign b_col1 = r_b_fwd ? r_b_fwd_above : r_rd_above;
    assign b_col0 = r_b_fwd ? r_b_fwd_two   : r_rd_two;

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            mem_above[r_b_c] <= r_b_cur;
        end
        if (accept) begin
            r_rd_above <= mem_above[c_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            mem_two[r_b_c] <= b_col1;
        end
        if (accept) begin
            r_rd_two <= mem_two[c_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
            r_win0    <= '0;
            r_win1    <= '0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_b_valid <= accept || (r_b_valid && !b_adv);
            if (b_adv) begin
                r_win0 <= r_win1;
                r_win1 <= {r_b_cur, b_col1, b_col0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_cur       <= cur;
            r_b_c         <= c_addr;
            r_b_orow      <= rgbk_pkg::POS_W'(r1 - 1'b1);
            r_b_ocol      <= rgbk_pkg::POS_W'(c1 - 1'b1);
            r_b_emit      <= emit;
            r_b_last      <= last;
            r_b_fwd       <= fwd;
            r_b_fwd_above <= r_b_cur;
            r_b_fwd_two   <= b_col1;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_q_data.px[i][0] = r_win0[i];
            o_q_data.px[i][1] = r_win1[i];
        end
        o_q_data.px[0][2] = b_col0;
        o_q_data.px[1][2] = b_col1;
        o_q_data.px[2][2] = r_b_cur;
        o_q_data.row      = r_b_orow;
        o_q_data.col      = r_b_ocol;
        o_q_data.last     = r_b_last;
    end

    assign o_q_push = b_adv && r_b_emit;

    `RGBK_ASSERT(a_accept_moves_b, (accept && r_b_valid) |-> b_adv, "stage B overwritten")
    `RGBK_ASSERT(a_push_room, o_q_push |-> !i_q_full, "window pushed into full queue")

endmodule

// ----- hdl/rgbk_back.sv -----
`include "rgb_3x3_kernel_filter_macros.svh"

module rgbk_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rgbk_pkg::t_mode     i_mode,
    input  logic                i_q_empty,
    input  rgbk_pkg::t_win      i_q_data,
    output logic                o_q_pop,
    output logic                empty,
    input  logic                pop,
    output rgbk_pkg::t_out_beat o_out
);

    localparam int OQ_DEPTH    = 4;
    localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);
    localparam int GAUSS_RECIP = 683;
    localparam int GAUSS_SHIFT = 11;
    localparam int AVG_RECIP   = 7282;
    localparam int AVG_SHIFT   = 16;
    localparam int PROD_W      = 25;

    function automatic logic signed [12:0] ksum(rgbk_pkg::t_mode mode,
                                                logic [2:0][2:0][7:0] p);
        logic signed [12:0] q [3][3];
        logic signed [12:0] s;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                q[i][j] = $signed({5'b0, p[i][j]});
            end
        end
        case (mode)
            rgbk_pkg::MODE_HILINE: begin
                s = q[2][0] + (q[2][1] <<< 1) + q[2][2]
                  - q[0][0] - (q[0][1] <<< 1) - q[0][2];
            end
            // floor(sum/24) = center + floor(edge sum / 2), then divide by 3
            rgbk_pkg::MODE_GAUSS: begin
                s = q[1][1] + ((q[0][1] + q[1][0] + q[1][2] + q[2][1]) >>> 1);
            end
            rgbk_pkg::MODE_EMBOSS: begin
                s = q[0][0] + q[0][1] - q[0][2] + q[1][0] + q[1][1] - q[1][2]
                  + q[2][0] - q[2][1] - q[2][2];
            end
            default: begin
                s = q[0][0] + q[0][1] + q[0][2] + q[1][0] + q[1][1] + q[1][2]
                  + q[2][0] + q[2][1] + q[2][2];
            end
        endcase
        return s;
    endfunction

    logic                    r_s1_valid;
    rgbk_pkg::t_mode         r_s1_mode;
    logic signed [12:0]      r_s1_val [3];
    logic signed [12:0]      s1_val [3];
    logic [rgbk_pkg::POS_W-1:0] r_s1_row, r_s1_col;
    logic                    r_s1_last;
    logic [2:0][2:0][7:0]    chp [3];
    logic [7:0]              res [3];
    logic [PROD_W-1:0]       prod [3];
    logic [12:0]             recip;
    logic [OQ_CNT_W:0]       occ;
    logic                    launch, oq_pop;

    rgbk_pkg::t_out_beat     r_oq [OQ_DEPTH];
    rgbk_pkg::t_out_beat     oq_in;
    logic [OQ_PTR_W-1:0]     r_wr, r_rd;
    logic [OQ_CNT_W-1:0]     r_cnt;

    assign occ     = (OQ_CNT_W + 1)'(r_cnt) + (OQ_CNT_W + 1)'(r_s1_valid);
    assign launch  = !i_q_empty && (occ < (OQ_CNT_W + 1)'(OQ_DEPTH));
    assign o_q_pop = launch;
    assign empty   = (r_cnt == '0);
    assign oq_pop  = pop && !empty;
    assign o_out   = r_oq[r_rd];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                chp[0][i][j] = i_q_data.px[i][j].red;
                chp[1][i][j] = i_q_data.px[i][j].green;
                chp[2][i][j] = i_q_data.px[i][j].blue;
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            s1_val[ch] = ksum(i_mode, chp[ch]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= launch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (launch) begin
            r_s1_mode <= i_mode;
            r_s1_row  <= i_q_data.row;
            r_s1_col  <= i_q_data.col;
            r_s1_last <= i_q_data.last;
            for (int ch = 0; ch < 3; ch++) begin
                r_s1_val[ch] <= s1_val[ch];
            end
        end
    end

    // constant division by reciprocal for gauss and average, clamp for the others
    assign recip = (r_s1_mode == rgbk_pkg::MODE_GAUSS) ? 13'(GAUSS_RECIP) : 13'(AVG_RECIP);

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = PROD_W'(r_s1_val[ch][11:0]) * PROD_W'(recip);
            case (r_s1_mode)
                rgbk_pkg::MODE_GAUSS: res[ch] = prod[ch][GAUSS_SHIFT +: 8];
                rgbk_pkg::MODE_AVG:   res[ch] = prod[ch][AVG_SHIFT +: 8];
                default: begin
                    if (r_s1_val[ch] < 0) begin
                        res[ch] = 8'd0;
                    end else if (r_s1_val[ch] > 13'sd255) begin
                        res[ch] = 8'd255;
                    end else begin
                        res[ch] = r_s1_val[ch][7:0];
                    end
                end
            endcase
        end
        oq_in.red_out       = res[0];
        oq_in.green_out     = res[1];
        oq_in.blue_out      = res[2];
        oq_in.out_row       = r_s1_row;
        oq_in.out_col       = r_s1_col;
        oq_in.last_of_frame = r_s1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (r_s1_valid) begin
                r_wr <= (r_wr == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (oq_pop) begin
                r_rd <= (r_rd == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({r_s1_valid, oq_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_oq[r_wr] <= oq_in;
        end
    end

    `RGBK_ASSERT(a_oq_credit, occ <= (OQ_CNT_W + 1)'(OQ_DEPTH), "result queue overbooked")
    `RGBK_ASSERT_NEXT(a_launch_lands, o_q_pop, r_s1_valid, "launched window lost")

endmodule

// ----- hdl/rgb_3x3_kernel_filter.sv -----
// 3x3 kernel filter over an RGB raster stream.
// Pixel input: queue style. Drive i_in and push; a beat is taken on a rising
// edge with push high and full low. frame_start puts the pixel at row 0, col 0.
// Results: queue style. o_out holds the oldest result while empty is low; it is
// taken on a rising edge with pop high. Only interior pixels give a result,
// tagged with row, column and a last-of-frame flag.
// Config: i_cfg_valid/o_cfg_ready with i_cfg_index (0 mode, 1 width, 2 height)
// and i_cfg_data; o_cfg_ready is always high. Write only while idle.
// Throughput: one pixel per cycle sustained while full stays low, set by the
// line store read issued on the accept cycle, a bypass for the store write
// still in flight, and the two-stage kernel pipeline.
// Path: the pixel that completes a window is registered in stage B; the window
// then passes the window queue, the kernel stage and the result queue.
// Reset: position and window clear, mode 3 (average), width and height 1024.
// The line stores are not cleared; the first two rows of a frame fill them.
// Stall: a four-beat result queue and a two-beat window queue absorb a stalled
// receiver; once they fill, full rises and the stream is held.
module rgb_3x3_kernel_filter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rgbk_pkg::t_in_beat  i_in,
    input  logic                push,
    output logic                full,
    output rgbk_pkg::t_out_beat o_out,
    output logic                empty,
    input  logic                pop,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [rgbk_pkg::DIM_W-1:0] i_cfg_data
);

    rgbk_pkg::t_cfg r_cfg;
    rgbk_pkg::t_win q_in, q_out;
    logic           q_push, q_full, q_pop, q_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= rgbk_pkg::MODE_AVG;
            r_cfg.width  <= rgbk_pkg::DIM_W'(rgbk_pkg::MAX_WIDTH);
            r_cfg.height <= rgbk_pkg::DIM_W'(rgbk_pkg::MAX_HEIGHT);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rgbk_pkg::CFG_MODE:   r_cfg.mode   <= rgbk_pkg::t_mode'(i_cfg_data[1:0]);
                rgbk_pkg::CFG_WIDTH:  r_cfg.width  <= i_cfg_data;
                rgbk_pkg::CFG_HEIGHT: r_cfg.height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rgbk_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .i_pix    (i_in),
        .o_full   (full),
        .o_q_push (q_push),
        .o_q_data (q_in),
        .i_q_full (q_full)
    );

    rgbk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    rgbk_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mode    (r_cfg.mode),
        .i_q_empty (q_empty),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_out     (o_out)
    );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT   = 250000;
    localparam int LATENCY_SLACK = 8;
    localparam int RANDOM_PIXELS = 1770;
    localparam int MAX_REPORTS   = 60;
    localparam int MAX_GAP       = 17;
    localparam int TALL_ROWS     = 40;
    // index with no register behind it
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic                          i_clk;
    logic                          i_rst_n;
    rgbk_pkg::t_in_beat            i_in;
    logic                          push;
    logic                          full;
    rgbk_pkg::t_out_beat           o_out;
    logic                          empty;
    logic                          pop;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [1:0]                    i_cfg_index;
    logic [rgbk_pkg::DIM_W-1:0]    i_cfg_data;

    rgb_3x3_kernel_filter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .push        (push),
        .full        (full),
        .o_out       (o_out),
        .empty       (empty),
        .pop         (pop),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // filter state mirror: line stores, two window columns, raster position
    logic [23:0]                line_above_q [rgbk_pkg::MAX_WIDTH];
    logic [23:0]                line_two_above_q [rgbk_pkg::MAX_WIDTH];
    logic [23:0]                win_left [3];
    logic [23:0]                win_mid [3];
    int                         col_pos;
    int                         row_pos;
    rgbk_pkg::t_mode            kern_mode;
    logic [rgbk_pkg::DIM_W-1:0] width_reg;
    logic [rgbk_pkg::DIM_W-1:0] height_reg;

    rgbk_pkg::t_out_beat        filtered_expect [$];

    int cycle_count;
    int mismatch_count;
    int pixels_taken;
    int results_checked;
    int frame_ends;
    int reg_writes;
    int results_by_mode [4];
    int push_max_gap;
    int pop_max_gap;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int clamp_dim(input int v, input int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [7:0] apply_kernel(input logic [2:0][2:0][7:0] p,
                                                input rgbk_pkg::t_mode m);
        int s;
        int v [3][3];
        int i;
        int j;
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
                v[i][j] = int'(p[i][j]);
        case (m)
            rgbk_pkg::MODE_HILINE: s = -v[0][0] - 2 * v[0][1] - v[0][2]
                                       + v[2][0] + 2 * v[2][1] + v[2][2];
            rgbk_pkg::MODE_GAUSS:  s = (4 * v[0][1] + 4 * v[1][0] + 8 * v[1][1]
                                        + 4 * v[1][2] + 4 * v[2][1]) / 24;
            rgbk_pkg::MODE_EMBOSS: s = v[0][0] + v[0][1] - v[0][2] + v[1][0] + v[1][1]
                                       - v[1][2] + v[2][0] - v[2][1] - v[2][2];
            default:               s = (v[0][0] + v[0][1] + v[0][2] + v[1][0] + v[1][1]
                                        + v[1][2] + v[2][0] + v[2][1] + v[2][2]) / 9;
        endcase
        if (s > 255) return 8'hFF;
        if (s < 0) return 8'h00;
        return 8'(s);
    endfunction

    task automatic predict_pixel(input rgbk_pkg::t_in_beat px);
        int w;
        int h;
        int c;
        int r;
        int ch;
        int i;
        logic [23:0] cur;
        logic [23:0] column [3];
        logic [2:0][2:0][7:0] win;
        logic [7:0] chan_res [3];
        rgbk_pkg::t_out_beat res;
        w = clamp_dim(int'(width_reg), rgbk_pkg::MAX_WIDTH);
        h = clamp_dim(int'(height_reg), rgbk_pkg::MAX_HEIGHT);
        if (px.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        // wrap counters left past the limits by a dimension change
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        c = col_pos;
        r = row_pos;
        cur = {px.blue_in, px.green_in, px.red_in};
        column[0] = line_two_above_q[c];
        column[1] = line_above_q[c];
        column[2] = cur;
        if (r >= 2 && c >= 2) begin
            for (ch = 0; ch < 3; ch++) begin
                for (i = 0; i < 3; i++) begin
                    win[i][0] = win_left[i][8*ch +: 8];
                    win[i][1] = win_mid[i][8*ch +: 8];
                    win[i][2] = column[i][8*ch +: 8];
                end
                chan_res[ch] = apply_kernel(win, kern_mode);
            end
            res.red_out       = chan_res[0];
            res.green_out     = chan_res[1];
            res.blue_out      = chan_res[2];
            res.out_row       = rgbk_pkg::POS_W'(r - 1);
            res.out_col       = rgbk_pkg::POS_W'(c - 1);
            res.last_of_frame = (r == h - 1) && (c == w - 1);
            filtered_expect.push_back(res);
            results_by_mode[kern_mode]++;
        end
        line_two_above_q[c] = column[1];
        line_above_q[c] = cur;
        for (i = 0; i < 3; i++) begin
            win_left[i] = win_mid[i];
            win_mid[i] = column[i];
        end
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic check_result(input rgbk_pkg::t_out_beat got);
        rgbk_pkg::t_out_beat want;
        string at;
        if (filtered_expect.size() == 0) begin
            flag_mismatch("result with none pending, row", got.out_row, -1);
        end else begin
            want = filtered_expect.pop_front();
            results_checked++;
            if (want.last_of_frame) frame_ends++;
            at = $sformatf(" at row %0d col %0d", want.out_row, want.out_col);
            if (got.red_out !== want.red_out)
                flag_mismatch({"red", at}, got.red_out, want.red_out);
            if (got.green_out !== want.green_out)
                flag_mismatch({"green", at}, got.green_out, want.green_out);
            if (got.blue_out !== want.blue_out)
                flag_mismatch({"blue", at}, got.blue_out, want.blue_out);
            if (got.out_row !== want.out_row)
                flag_mismatch({"out_row", at}, got.out_row, want.out_row);
            if (got.out_col !== want.out_col)
                flag_mismatch({"out_col", at}, got.out_col, want.out_col);
            if (got.last_of_frame !== want.last_of_frame)
                flag_mismatch({"last_of_frame", at}, got.last_of_frame, want.last_of_frame);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cycle_count = 0;
            col_pos = 0;
            row_pos = 0;
            kern_mode = rgbk_pkg::MODE_AVG;
            width_reg = rgbk_pkg::DIM_W'(rgbk_pkg::MAX_WIDTH);
            height_reg = rgbk_pkg::DIM_W'(rgbk_pkg::MAX_HEIGHT);
            for (int i = 0; i < 3; i++) begin
                win_left[i] = '0;
                win_mid[i] = '0;
            end
        end else if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped at cycle limit, %0d results still pending",
                     filtered_expect.size());
            $display("** rgb_3x3_kernel_filter: FAILED **");
            $finish;
        end else begin
            cycle_count++;
            if (i_cfg_valid && o_cfg_ready) begin
                reg_writes++;
                case (i_cfg_index)
                    rgbk_pkg::CFG_MODE:   kern_mode = rgbk_pkg::t_mode'(i_cfg_data[1:0]);
                    rgbk_pkg::CFG_WIDTH:  width_reg = i_cfg_data;
                    rgbk_pkg::CFG_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (push && !full) begin
                pixels_taken++;
                predict_pixel(i_in);
            end
            if (pop && !empty) check_result(o_out);
        end
    end

    // result side: random stall before each beat
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = $urandom_range(0, pop_max_gap);
            @(negedge i_clk);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty !== 1'b0);
        end
    end

    task automatic send_pixel(input rgbk_pkg::t_in_beat px, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in <= px;
        push <= 1'b1;
        do @(posedge i_clk); while (full !== 1'b0);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        push <= 1'b0;
        while (filtered_expect.size() != 0) @(negedge i_clk);
        repeat (LATENCY_SLACK) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [rgbk_pkg::DIM_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // upper data bits are don't-care for the mode register
    task automatic set_mode(input rgbk_pkg::t_mode m);
        logic [rgbk_pkg::DIM_W-1:0] d;
        d = rgbk_pkg::DIM_W'($urandom);
        d[1:0] = m;
        write_reg(rgbk_pkg::CFG_MODE, d);
    endtask

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic rgbk_pkg::t_in_beat make_pixel(input bit sof);
        rgbk_pkg::t_in_beat px;
        px.red_in      = pick_sample();
        px.green_in    = pick_sample();
        px.blue_in     = pick_sample();
        px.frame_start = sof;
        return px;
    endfunction

    function automatic logic [rgbk_pkg::DIM_W-1:0] pick_dim(input bit allow_huge);
        case ($urandom_range(0, 9))
            0: return rgbk_pkg::DIM_W'($urandom_range(0, 2));
            1: return rgbk_pkg::DIM_W'($urandom_range(13, 24));
            2: return allow_huge ? rgbk_pkg::DIM_W'($urandom_range(1025, 2047))
                                 : rgbk_pkg::DIM_W'($urandom_range(3, 12));
            default: return rgbk_pkg::DIM_W'($urandom_range(3, 12));
        endcase
    endfunction

    // reset mode and height: 5-wide rows, average kernel, no row wrap
    task automatic test_reset_defaults();
        push_max_gap = 0;
        pop_max_gap = 0;
        write_reg(rgbk_pkg::CFG_WIDTH, rgbk_pkg::DIM_W'(5));
        for (int i = 0; i < 5 * 8; i++)
            send_pixel(make_pixel(i == 0), 0);
        drain_results();
    endtask

    // 3-wide, 6-tall frame; rows/columns of 0 and 255 drive every kernel's output to 0 and 255
    task automatic test_kernel_extremes();
        rgbk_pkg::t_in_beat px;
        push_max_gap = MAX_GAP;
        pop_max_gap = MAX_GAP;
        write_reg(rgbk_pkg::CFG_WIDTH, rgbk_pkg::DIM_W'(3));
        write_reg(rgbk_pkg::CFG_HEIGHT, rgbk_pkg::DIM_W'(6));
        set_mode(rgbk_pkg::MODE_HILINE);
        for (int r = 0; r < 6; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (c == 2 && r >= 3) begin
                    drain_results();
                    case (r)
                        3: set_mode(rgbk_pkg::MODE_EMBOSS);
                        4: set_mode(rgbk_pkg::MODE_GAUSS);
                        default: set_mode(rgbk_pkg::MODE_AVG);
                    endcase
                end
                px.red_in      = (r >= 2) ? 8'hFF : 8'h00;
                px.green_in    = ~px.red_in;
                px.blue_in     = (c < 2) ? 8'hFF : 8'h00;
                px.frame_start = (r == 0 && c == 0);
                send_pixel(px, $urandom_range(0, push_max_gap));
            end
        end
        drain_results();
    endtask

    // width below range, height above range: 3-wide rows, no wrap over many rows
    task automatic test_tall_frame();
        push_max_gap = 0;
        pop_max_gap = 0;
        write_reg(rgbk_pkg::CFG_WIDTH, '0);
        write_reg(rgbk_pkg::CFG_HEIGHT, '1);
        set_mode(rgbk_pkg::t_mode'($urandom_range(0, 3)));
        for (int i = 0; i < 3 * TALL_ROWS; i++)
            send_pixel(make_pixel(i == 0), 0);
        drain_results();
    endtask

    // random phases; width only grows together with a new frame so that
    // the line stores are always filled before they are read
    task automatic test_random_frames();
        int sent;
        int n;
        bit fresh;
        logic [rgbk_pkg::DIM_W-1:0] wv;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            push_max_gap = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            pop_max_gap  = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            fresh = ($urandom_range(0, 2) == 0);
            set_mode(rgbk_pkg::t_mode'($urandom_range(0, 3)));
            if ($urandom_range(0, 3) != 0) begin
                wv = pick_dim(1'b0);
                if (clamp_dim(int'(wv), rgbk_pkg::MAX_WIDTH) >
                    clamp_dim(int'(width_reg), rgbk_pkg::MAX_WIDTH))
                    fresh = 1'b1;
                write_reg(rgbk_pkg::CFG_WIDTH, wv);
                write_reg(rgbk_pkg::CFG_HEIGHT, pick_dim(1'b1));
            end
            if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE, rgbk_pkg::DIM_W'($urandom));
            n = $urandom_range(8, 60);
            for (int i = 0; i < n; i++)
                send_pixel(make_pixel((i == 0 && fresh) || $urandom_range(0, 49) == 0),
                           $urandom_range(0, push_max_gap));
            sent += n;
            drain_results();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in = '0;
        push = 1'b0;
        pop = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = rgbk_pkg::CFG_MODE;
        i_cfg_data = '0;
        mismatch_count = 0;
        pixels_taken = 0;
        results_checked = 0;
        frame_ends = 0;
        reg_writes = 0;
        results_by_mode = '{0, 0, 0, 0};
        push_max_gap = 0;
        pop_max_gap = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_kernel_extremes();
        test_tall_frame();
        test_random_frames();

        $display("Sent %0d pixels with %0d register writes; checked %0d results, %0d frame ends.",
                 pixels_taken, reg_writes, results_checked, frame_ends);
        $display("By kernel: hi-line %0d, gauss %0d, emboss %0d, average %0d; %0d mismatches.",
                 results_by_mode[rgbk_pkg::MODE_HILINE], results_by_mode[rgbk_pkg::MODE_GAUSS],
                 results_by_mode[rgbk_pkg::MODE_EMBOSS], results_by_mode[rgbk_pkg::MODE_AVG],
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("** rgb_3x3_kernel_filter: PASSED **");
        end else begin
            $display("** rgb_3x3_kernel_filter: FAILED **");
        end
        $finish;
    end

endmodule

// ----- rgb_3x3_kernel_filter.f -----
+incdir+hdl
hdl/rgbk_pkg.sv
hdl/rgbk_queue.sv
hdl/rgbk_front.sv
hdl/rgbk_back.sv
hdl/rgb_3x3_kernel_filter.sv
sim/testbench.sv
